### sv/brf_pkg.sv
`default_nettype none

package brf_pkg;

  // Width of capacity, fill level and found position
  localparam int unsigned CNT_W = 11;
  localparam int unsigned BYTE_W = 8;
  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  // Configuration register indexes
  localparam int unsigned REG_CAPACITY = 0;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_FIND = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_HOLD
  } state_e;

  // Which result gets loaded into the output register
  typedef enum logic [1:0] {
    RES_NOW,
    RES_POP,
    RES_FIND
  } res_e;

  typedef struct packed {
    logic accept;
    op_e  op;
    logic scan_step;
    logic out_load;
    res_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### sv/byte_ring_fifo_with_delimiter_find_top.sv
// Byte ring FIFO with delimiter search.
// Push, no-op, failed pop and find on empty load the result from the request;
// pop loads it from the registered read of the byte store (state S_POP); find
// scans one byte a cycle in S_SCAN to the match or fill level, then S_HOLD.
// Requests are taken only in idle with the output free, so pop and find hold
// off new ones. Reset zeroes indices and fill count, capacity 1024; no clear pass.
`default_nettype none

module byte_ring_fifo_with_delimiter_find_top #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  data_in_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       data_out_o,
  output logic [10:0]      found_position_o,
  output logic [1:0]       status_o,
  output logic [10:0]      fill_level_o,
  // APB register port; capacity at address 0
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import brf_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_rdata;

  // Only the capacity register exists; other addresses are ignored.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == 2'(REG_CAPACITY));
  assign prdata = (paddr == 2'(REG_CAPACITY)) ? 32'(cfg_rdata) : '0;

  brf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_e'(operation_i)),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  brf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .data_in_i        (data_in_i),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (pwdata[CNT_W-1:0]),
    .cfg_rdata_o      (cfg_rdata),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .data_out_o       (data_out_o),
    .found_position_o (found_position_o),
    .status_o         (status_o),
    .fill_level_o     (fill_level_o)
  );

endmodule

`default_nettype wire

### sv/brf_ctrl.sv
`default_nettype none

module brf_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire brf_pkg::op_e op_i,
  input  wire brf_pkg::sts_t sts_i,
  output brf_pkg::cmd_t     cmd_o,
  output logic              in_stall_o
);
  import brf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = !sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          cmd_o.accept  = 1'b1;
          cmd_o.op      = op_i;
          cmd_o.out_sel = RES_NOW;
          unique case (op_i)
            OP_POP: begin
              if (sts_i.empty) cmd_o.out_load = 1'b1;
              else state_d = S_POP;
            end
            OP_FIND: begin
              if (sts_i.empty) cmd_o.out_load = 1'b1;
              else state_d = S_SCAN;
            end
            default: cmd_o.out_load = 1'b1;
          endcase
        end
      end
      S_POP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = RES_POP;
          state_d        = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = RES_FIND;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### sv/brf_dp.sv
`default_nettype none

module brf_dp #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire brf_pkg::cmd_t                cmd_i,
  output brf_pkg::sts_t                     sts_o,
  input  wire logic [brf_pkg::BYTE_W-1:0]   data_in_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [brf_pkg::CNT_W-1:0]    cfg_wdata_i,
  output logic [brf_pkg::CNT_W-1:0]         cfg_rdata_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [brf_pkg::BYTE_W-1:0]        data_out_o,
  output logic [brf_pkg::CNT_W-1:0]         found_position_o,
  output logic [1:0]                        status_o,
  output logic [brf_pkg::CNT_W-1:0]         fill_level_o
);
  import brf_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] CapRst =
    (DEPTH < 32'(CAP_RESET)) ? CNT_W'(DEPTH) : CAP_RESET;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rd_q;

  logic [CNT_W-1:0] cap_raw_q, cap_q, cap_eff;
  logic [AW-1:0]    rd_idx_q, wr_idx_q, scan_idx_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cmp_cnt_q, pos_q;
  logic             cmp_vld_q;
  logic [BYTE_W-1:0] delim_q;

  logic push_ok, pop_ok, find_go, full, empty, scan_hit, scan_last, scan_done;
  logic out_free;
  status_e status_now;

  logic             out_valid_q;
  logic [BYTE_W-1:0] data_out_q;
  logic [CNT_W-1:0] pos_out_q, fill_q;
  status_e          status_q;

  function automatic logic [AW-1:0] ring_next(logic [AW-1:0] idx, logic [CNT_W-1:0] cap);
    logic [31:0] nxt;
    nxt = 32'(idx) + 32'd1;
    return (nxt >= 32'(cap)) ? '0 : nxt[AW-1:0];
  endfunction

  // Saturate the written capacity into 1..DEPTH
  always_comb begin
    if (cfg_wdata_i == '0) cap_eff = CNT_W'(1);
    else if (32'(cfg_wdata_i) > DEPTH) cap_eff = CNT_W'(DEPTH);
    else cap_eff = cfg_wdata_i;
  end

  assign full      = (count_q == cap_q);
  assign empty     = (count_q == '0);
  assign push_ok   = cmd_i.accept && (cmd_i.op == OP_PUSH) && !full;
  assign pop_ok    = cmd_i.accept && (cmd_i.op == OP_POP) && !empty;
  assign find_go   = cmd_i.accept && (cmd_i.op == OP_FIND) && !empty;
  assign scan_hit  = (rd_q == delim_q);
  assign scan_last = ((cmp_cnt_q + CNT_W'(1)) == count_q);
  assign scan_done = cmp_vld_q && (scan_hit || scan_last);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    count_d = count_q;
    if (push_ok) count_d = count_q + CNT_W'(1);
    else if (pop_ok) count_d = count_q - CNT_W'(1);
  end

  always_comb begin
    status_now = ST_OK;
    if (cmd_i.op == OP_PUSH && full) status_now = ST_FULL;
    else if (cmd_i.op == OP_POP && empty) status_now = ST_EMPTY;
  end

  // Byte store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (push_ok) mem_q[wr_idx_q] <= data_in_i;
    if (pop_ok) rd_q <= mem_q[rd_idx_q];
    else if (cmd_i.scan_step) rd_q <= mem_q[scan_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_raw_q <= CAP_RESET;
      cap_q     <= CapRst;
      rd_idx_q  <= '0;
      wr_idx_q  <= '0;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
    end else if (cfg_we_i) begin
      cap_raw_q <= cfg_wdata_i;
      cap_q     <= cap_eff;
      rd_idx_q  <= '0;
      wr_idx_q  <= '0;
      count_q   <= '0;
    end else begin
      count_q <= count_d;
      if (push_ok) wr_idx_q <= ring_next(wr_idx_q, cap_q);
      if (pop_ok) rd_idx_q <= ring_next(rd_idx_q, cap_q);
      if (find_go) cmp_vld_q <= 1'b0;
      else if (cmd_i.scan_step) cmp_vld_q <= 1'b1;
    end
  end

  // Scan walker
  always_ff @(posedge clk_i) begin
    if (find_go) begin
      scan_idx_q <= rd_idx_q;
      cmp_cnt_q  <= '0;
      delim_q    <= data_in_i;
    end else if (cmd_i.scan_step) begin
      scan_idx_q <= ring_next(scan_idx_q, cap_q);
      if (cmp_vld_q && !scan_hit) cmp_cnt_q <= cmp_cnt_q + CNT_W'(1);
      if (scan_done) pos_q <= scan_hit ? (cmp_cnt_q + CNT_W'(1)) : '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      unique case (cmd_i.out_sel)
        RES_POP: begin
          data_out_q <= rd_q;
          pos_out_q  <= '0;
          status_q   <= ST_OK;
          fill_q     <= count_q;
        end
        RES_FIND: begin
          data_out_q <= '0;
          pos_out_q  <= pos_q;
          status_q   <= ST_OK;
          fill_q     <= count_q;
        end
        default: begin
          data_out_q <= '0;
          pos_out_q  <= '0;
          status_q   <= status_now;
          fill_q     <= count_d;
        end
      endcase
    end
  end

  assign sts_o.empty     = empty;
  assign sts_o.scan_done = scan_done;
  assign sts_o.out_free  = out_free;

  assign cfg_rdata_o      = cap_raw_q;
  assign out_valid_o      = out_valid_q;
  assign data_out_o       = data_out_q;
  assign found_position_o = pos_out_q;
  assign status_o         = status_q;
  assign fill_level_o     = fill_q;

  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q) else $error("fill count above capacity");

  a_idx_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(rd_idx_q) < 32'(cap_q)) && (32'(wr_idx_q) < 32'(cap_q)))
    else $error("ring index outside capacity");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ok && !cfg_we_i |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("pop did not decrement count");

  a_push_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept && cmd_i.op == OP_PUSH && full && !cfg_we_i |=> $stable(wr_idx_q))
    else $error("dropped push moved write index");

endmodule

`default_nettype wire

### tb/tb_byte_ring_fifo_with_delimiter_find_top.sv
`timescale 1ns / 100ps

module tb_byte_ring_fifo_with_delimiter_find_top;
  import brf_pkg::*;

  localparam int unsigned RING_SLOTS    = 1024;
  localparam logic [7:0]  DELIM_BYTE    = 8'h4D;
  // worst find scans 1024 bytes, so leave plenty of room for one
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } fifo_req_t;

  typedef struct packed {
    logic [7:0]       data;
    logic [CNT_W-1:0] pos;
    status_e          st;
    logic [CNT_W-1:0] fill;
  } fifo_resp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request channel
  logic        in_valid = 1'b0;
  logic        in_stall;
  op_e         in_op    = OP_NOP;
  logic [7:0]  in_data  = '0;
  // result channel
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  data_out;
  logic [10:0] found_position;
  logic [1:0]  status;
  logic [10:0] fill_level;
  // register port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [1:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  byte_ring_fifo_with_delimiter_find_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .operation_i      (in_op),
    .data_in_i        (in_data),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .data_out_o       (data_out),
    .found_position_o (found_position),
    .status_o         (status),
    .fill_level_o     (fill_level),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // ---------------------------------------------------------------------------
  // Shadow ring: mirrors capacity, pointers, count and stored bytes.
  // Updated in request acceptance order; capacity writes happen only when idle.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] cap_shadow = CAP_RESET;
  logic [7:0]       ring_mem [RING_SLOTS];
  int unsigned      rd_pos = 0;
  int unsigned      wr_pos = 0;
  int unsigned      held   = 0;

  fifo_req_t  req_q [$];   // requests waiting to be driven
  fifo_resp_t resp_q [$];  // predicted results, oldest first

  int unsigned err_cnt  = 0;
  int unsigned idle_pct = 25;  // chance of starting an idle burst, per side
  logic        hold_req   = 1'b0;
  logic        hold_fired = 1'b0;
  int unsigned hold_left  = 0;

  function automatic fifo_resp_t ring_apply(input op_e op, input logic [7:0] b);
    fifo_resp_t  r;
    int unsigned lim;
    int unsigned idx;
    // 0 acts as one slot, anything past the ring size saturates
    lim = (cap_shadow == 0) ? 1 : ((cap_shadow > RING_SLOTS) ? RING_SLOTS : cap_shadow);
    r.data = '0;
    r.pos  = '0;
    r.st   = ST_OK;
    case (op)
      OP_PUSH: begin
        if (held >= lim) begin
          r.st = ST_FULL;
        end else begin
          ring_mem[wr_pos] = b;
          wr_pos = (wr_pos + 1 >= lim) ? 0 : wr_pos + 1;
          held++;
        end
      end
      OP_POP: begin
        if (held == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.data = ring_mem[rd_pos];
          rd_pos = (rd_pos + 1 >= lim) ? 0 : rd_pos + 1;
          held--;
        end
      end
      OP_FIND: begin
        idx = rd_pos;
        for (int unsigned i = 0; i < held; i++) begin
          if (ring_mem[idx] == b) begin
            r.pos = CNT_W'(i + 1);
            break;
          end
          idx = (idx + 1 >= lim) ? 0 : idx + 1;
        end
      end
      default: ;
    endcase
    r.fill = CNT_W'(held);
    return r;
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: offers queued requests, random idle bursts between them.
  // A request is held unchanged until accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : req_driver
    logic        next_valid;
    fifo_req_t   rq;
    int unsigned gap_left;
    if (rst_ni) begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        resp_q.push_back(ring_apply(in_op, in_data));
        next_valid = 1'b0;
      end
      if (!next_valid && req_q.size() != 0) begin
        if (gap_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          gap_left = $urandom_range(1, 5);
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          rq = req_q.pop_front();
          in_op   <= rq.op;
          in_data <= rq.data;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end else begin
      gap_left = 0;
    end
  end

  // long hold-off on the result side, started once on request
  always @(posedge clk_i) begin : hold_timer
    if (hold_req && !hold_fired) begin
      hold_fired <= 1'b1;
      hold_left  <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : resp_stall_gen
    int unsigned stall_left;
    logic        burst;
    burst = 1'b0;
    if (stall_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
      stall_left = $urandom_range(1, 5);
    if (stall_left != 0) begin
      stall_left--;
      burst = 1'b1;
    end
    out_stall <= burst || (hold_left != 0);
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : resp_checker
    fifo_resp_t  want;
    int unsigned quiet_cycles;
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && !out_stall) begin
        if (resp_q.size() == 0) begin
          flag_error($sformatf("result with no request pending: data %02h pos %0d st %0d fill %0d",
                               data_out, found_position, status, fill_level));
        end else begin
          want = resp_q.pop_front();
          if (data_out !== want.data || found_position !== want.pos ||
              status !== want.st || fill_level !== want.fill)
            flag_error($sformatf({"mismatch: exp data %02h pos %0d st %0d fill %0d,",
                                  " got data %02h pos %0d st %0d fill %0d"},
                                 want.data, want.pos, want.st, want.fill,
                                 data_out, found_position, status, fill_level));
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[byte_ring_fifo_with_delimiter_find_top] ERROR");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_req(input op_e op, input logic [7:0] b);
    req_q.push_back(fifo_req_t'{op, b});
  endtask

  // wait until every request is taken and every result checked
  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid || resp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write of the capacity register; also empties the shadow ring
  task automatic cap_write(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 2'(REG_CAPACITY * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_shadow = value[CNT_W-1:0];
    rd_pos = 0;
    wr_pos = 0;
    held   = 0;
  endtask

  // mixed traffic; half the bytes come from a tiny alphabet so finds hit
  task automatic queue_mixed(input int unsigned n);
    int unsigned pick;
    logic [7:0]  b;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      b = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
      if (pick < 45)      queue_req(OP_PUSH, b);
      else if (pick < 75) queue_req(OP_POP, b);
      else if (pick < 95) queue_req(OP_FIND, b);
      else                queue_req(OP_NOP, b);
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset capacity: empty cases, ends of the byte range, delimiter
    queue_req(OP_POP,  8'h00);
    queue_req(OP_FIND, DELIM_BYTE);
    queue_req(OP_NOP,  8'hFF);
    queue_req(OP_PUSH, 8'h00);
    queue_req(OP_PUSH, 8'hFF);
    queue_req(OP_PUSH, DELIM_BYTE);
    queue_req(OP_FIND, DELIM_BYTE);
    queue_req(OP_FIND, 8'h00);
    queue_req(OP_FIND, 8'h12);
    queue_req(OP_NOP,  8'h00);
    queue_req(OP_POP,  8'h00);
    queue_req(OP_POP,  8'h00);
    queue_req(OP_POP,  8'h00);
    queue_req(OP_POP,  8'h00);
    wait_drained();

    // capacity 0 behaves as one slot: second push is dropped
    cap_write(32'd0);
    queue_req(OP_PUSH, 8'hA5);
    queue_req(OP_PUSH, 8'h5A);
    queue_req(OP_FIND, 8'hA5);
    queue_req(OP_POP,  8'h00);
    queue_req(OP_FIND, 8'hA5);
    wait_drained();

    // small rings, random traffic
    cap_write(32'd2);   queue_mixed(100); wait_drained();
    cap_write(32'd3);   queue_mixed(100); wait_drained();
    cap_write(32'd5);   queue_mixed(100); wait_drained();

    // fill an 8-slot ring while the result side holds off
    cap_write(32'd8);
    queue_mixed(100);
    @(posedge clk_i);
    hold_req <= 1'b1;
    wait_drained();

    idle_pct = 0;
    cap_write(32'd17);  queue_mixed(100); wait_drained();
    idle_pct = 25;
    cap_write(32'd64);  queue_mixed(100); wait_drained();
    cap_write(32'd1);   queue_mixed(100); wait_drained();

    // all ones saturates to the full ring; fill it past the top
    cap_write(32'hFFFF_FFFF);
    for (int unsigned i = 0; i < RING_SLOTS + 6; i++)
      queue_req(OP_PUSH, 8'($urandom_range(0, 254)));
    queue_req(OP_FIND, 8'hFF);   // absent, scans every byte
    queue_req(OP_POP,  8'h00);
    queue_req(OP_PUSH, 8'hFF);
    queue_req(OP_FIND, 8'hFF);   // match at the newest byte
    queue_mixed(60);
    wait_drained();

    // last stretch without idling on either side
    idle_pct = 0;
    cap_write(32'd1024);
    queue_mixed(60);
    wait_drained();

    if (err_cnt == 0 && resp_q.size() == 0) begin
      $display("[byte_ring_fifo_with_delimiter_find_top] OK");
    end else begin
      $display("[byte_ring_fifo_with_delimiter_find_top] ERROR");
    end
    $finish;
  end

endmodule
